// ===== rtl/prp_pkg.sv =====
`default_nettype none

package prp_pkg;

    // Point format
    localparam int COORD_WIDTH     = 24;
    localparam int COORD_FRAC_BITS = 8;

    // Register formats
    localparam int TRIG_W     = 16;   // Q1.14 cosine / sine
    localparam int TRIG_SHIFT = 14;
    localparam int F_W        = 16;   // focal distance
    localparam int CTR_W      = 12;   // screen center
    localparam int CFG_W      = 16;   // widest register
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_W      = 16;

    // Pitch stage: products, sums, rotated y1 / z1
    localparam int P1_W = COORD_WIDTH + TRIG_W;
    localparam int S1_W = P1_W + 1;
    localparam int R1_W = S1_W - TRIG_SHIFT;

    // Yaw stage: products, sums, rotated x2 / z2
    localparam int P2_W = R1_W + TRIG_W;
    localparam int S2_W = P2_W + 1;
    localparam int R2_W = S2_W - TRIG_SHIFT;

    // Projection
    localparam int FSH_W  = F_W + COORD_FRAC_BITS + 1;
    localparam int DEN_W  = ((R2_W > FSH_W) ? R2_W : FSH_W) + 1;
    localparam int DENM_W = DEN_W - 1;
    localparam int XF_W   = ((R2_W > R1_W) ? R2_W : R1_W) + F_W + 1;
    localparam int CXD_W  = DEN_W + CTR_W + 1;
    localparam int NUM_W  = ((XF_W > CXD_W) ? XF_W : CXD_W) + 1;

    // Divider: one quotient bit per stage, quotient beyond 16 bits saturates
    localparam int Q_W      = OUT_W;
    localparam int DIV_W    = ((NUM_W > DENM_W + Q_W) ? NUM_W : DENM_W + Q_W) + 1;
    localparam int LANE_LAT = Q_W + 1;

    localparam logic signed [OUT_W-1:0] SAT_MAX = OUT_W'(2**(OUT_W-1) - 1);
    localparam logic signed [OUT_W-1:0] SAT_MIN = OUT_W'(-(2**(OUT_W-1)));
    localparam logic [Q_W-1:0]          POS_LIM = Q_W'(2**(OUT_W-1) - 1);
    localparam logic [Q_W-1:0]          NEG_LIM = Q_W'(2**(OUT_W-1));

    // Register reset values
    localparam logic signed [TRIG_W-1:0] COS_RESET   = TRIG_W'(16384);
    localparam logic signed [TRIG_W-1:0] SIN_RESET   = TRIG_W'(0);
    localparam logic [F_W-1:0]           FOCAL_RESET = F_W'(200);
    localparam logic [CTR_W-1:0]         CX_RESET    = CTR_W'(400);
    localparam logic [CTR_W-1:0]         CY_RESET    = CTR_W'(300);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_PITCH = 3'd0,
        CFG_SIN_PITCH = 3'd1,
        CFG_COS_YAW   = 3'd2,
        CFG_SIN_YAW   = 3'd3,
        CFG_FOCAL     = 3'd4,
        CFG_CENTER_X  = 3'd5,
        CFG_CENTER_Y  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_pitch;
        logic signed [TRIG_W-1:0] sin_pitch;
        logic signed [TRIG_W-1:0] cos_yaw;
        logic signed [TRIG_W-1:0] sin_yaw;
    } trig_cfg_t;

    typedef struct packed {
        logic [F_W-1:0]   focal_distance;
        logic [CTR_W-1:0] center_x;
        logic [CTR_W-1:0] center_y;
    } proj_cfg_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] screen_x;
        logic signed [OUT_W-1:0] screen_y;
        logic                    behind_camera;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/point_rotate_project_unit.sv =====
`default_nettype none

// Rotates each 3D point (Q15.8) about X then Y with the Q1.14 cosine/sine
// registers and projects it: screen = coord*f/(z+f) + center, Y negated,
// truncated toward zero and saturated to 16 bits; a point with z+f <= 0 comes
// out with behind_camera set and zero screen values. One point per clock while
// the skid register is empty. The divider resolves one quotient bit per stage
// (16 stages plus a setup stage); it sits behind seven stages of multiply / add
// for rotation and projection, and ahead of the output word. Input ready drops
// only when both the output word and the one-word skid register behind it are
// full. Register writes take effect at once and are meant for when no point is
// in flight.
module point_rotate_project_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wen,
    input  logic [prp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [prp_pkg::CFG_W-1:0]              cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [prp_pkg::COORD_WIDTH-1:0] s_x_in,
    input  logic signed [prp_pkg::COORD_WIDTH-1:0] s_y_in,
    input  logic signed [prp_pkg::COORD_WIDTH-1:0] s_z_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [prp_pkg::OUT_W-1:0]       m_screen_x,
    output logic signed [prp_pkg::OUT_W-1:0]       m_screen_y,
    output logic                                   m_behind_camera
);

    prp_pkg::trig_cfg_t trig_reg;
    prp_pkg::proj_cfg_t proj_reg;

    logic en;

    logic                                 r_valid;
    logic signed [prp_pkg::R2_W-1:0]      r_x2, r_z2;
    logic signed [prp_pkg::R1_W-1:0]      r_y1;

    logic                                 p_valid, p_behind;
    logic signed [prp_pkg::NUM_W-1:0]     p_nx, p_ny;
    logic [prp_pkg::DENM_W-1:0]           p_den;

    logic signed [prp_pkg::OUT_W-1:0]     div_x, div_y;
    logic [prp_pkg::LANE_LAT-1:0]         dv_reg, db_reg;

    prp_pkg::result_t push_word;
    prp_pkg::result_t head_reg, skid_reg;
    logic             head_valid_reg, head_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             push, pop;
    logic             head_load, head_from_skid, skid_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_reg.cos_pitch      <= prp_pkg::COS_RESET;
            trig_reg.sin_pitch      <= prp_pkg::SIN_RESET;
            trig_reg.cos_yaw        <= prp_pkg::COS_RESET;
            trig_reg.sin_yaw        <= prp_pkg::SIN_RESET;
            proj_reg.focal_distance <= prp_pkg::FOCAL_RESET;
            proj_reg.center_x       <= prp_pkg::CX_RESET;
            proj_reg.center_y       <= prp_pkg::CY_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                prp_pkg::CFG_COS_PITCH: trig_reg.cos_pitch      <= cfg_wdata;
                prp_pkg::CFG_SIN_PITCH: trig_reg.sin_pitch      <= cfg_wdata;
                prp_pkg::CFG_COS_YAW:   trig_reg.cos_yaw        <= cfg_wdata;
                prp_pkg::CFG_SIN_YAW:   trig_reg.sin_yaw        <= cfg_wdata;
                prp_pkg::CFG_FOCAL:     proj_reg.focal_distance <= cfg_wdata;
                prp_pkg::CFG_CENTER_X:  proj_reg.center_x <= cfg_wdata[prp_pkg::CTR_W-1:0];
                prp_pkg::CFG_CENTER_Y:  proj_reg.center_y <= cfg_wdata[prp_pkg::CTR_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves whenever the skid slot is free
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    prp_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .x_in      (s_x_in),
        .y_in      (s_y_in),
        .z_in      (s_z_in),
        .trig      (trig_reg),
        .out_valid (r_valid),
        .x2        (r_x2),
        .z2        (r_z2),
        .y1        (r_y1)
    );

    prp_project u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .x2        (r_x2),
        .z2        (r_z2),
        .y1        (r_y1),
        .proj      (proj_reg),
        .out_valid (p_valid),
        .behind    (p_behind),
        .nx        (p_nx),
        .ny        (p_ny),
        .den       (p_den)
    );

    prp_div_lane u_div_x (
        .aclk   (aclk),
        .en     (en),
        .num    (p_nx),
        .den    (p_den),
        .result (div_x)
    );

    prp_div_lane u_div_y (
        .aclk   (aclk),
        .en     (en),
        .num    (p_ny),
        .den    (p_den),
        .result (div_y)
    );

    // valid and behind flag ride alongside the divider lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= '0;
        end else if (en) begin
            dv_reg <= {dv_reg[prp_pkg::LANE_LAT-2:0], p_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            db_reg <= {db_reg[prp_pkg::LANE_LAT-2:0], p_behind};
        end
    end

    always_comb begin
        push_word.behind_camera = db_reg[prp_pkg::LANE_LAT-1];
        push_word.screen_x      = db_reg[prp_pkg::LANE_LAT-1] ? '0 : div_x;
        push_word.screen_y      = db_reg[prp_pkg::LANE_LAT-1] ? '0 : div_y;
    end

    assign push = en && dv_reg[prp_pkg::LANE_LAT-1];
    assign pop  = head_valid_reg && m_ready;

    // output word plus one skid word
    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_load       = 1'b0;
        head_from_skid  = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg) begin
            if (pop) begin
                head_from_skid  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!head_valid_reg || pop) begin
                head_load       = 1'b1;
                head_valid_next = 1'b1;
            end else begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_load) begin
            head_reg <= push_word;
        end else if (head_from_skid) begin
            head_reg <= skid_reg;
        end
        if (skid_load) begin
            skid_reg <= push_word;
        end
    end

    assign m_valid         = head_valid_reg;
    assign m_screen_x      = head_reg.screen_x;
    assign m_screen_y      = head_reg.screen_y;
    assign m_behind_camera = head_reg.behind_camera;

endmodule

`default_nettype wire

// ===== rtl/prp_rotate.sv =====
`default_nettype none

// Pitch then yaw rotation, four stages: multiply, sum/shift, multiply, sum/shift.
module prp_rotate (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  logic signed [prp_pkg::COORD_WIDTH-1:0]   x_in,
    input  logic signed [prp_pkg::COORD_WIDTH-1:0]   y_in,
    input  logic signed [prp_pkg::COORD_WIDTH-1:0]   z_in,
    input  prp_pkg::trig_cfg_t                       trig,
    output logic                                     out_valid,
    output logic signed [prp_pkg::R2_W-1:0]          x2,
    output logic signed [prp_pkg::R2_W-1:0]          z2,
    output logic signed [prp_pkg::R1_W-1:0]          y1
);

    logic [3:0] v_reg;

    // stage 1
    logic signed [prp_pkg::COORD_WIDTH-1:0] xa_reg;
    logic signed [prp_pkg::P1_W-1:0] p_ycp_next, p_zsp_next, p_ysp_next, p_zcp_next;
    logic signed [prp_pkg::P1_W-1:0] p_ycp_reg, p_zsp_reg, p_ysp_reg, p_zcp_reg;

    // stage 2
    logic signed [prp_pkg::COORD_WIDTH-1:0] xb_reg;
    logic signed [prp_pkg::S1_W-1:0] s_y1_next, s_z1_next;
    logic signed [prp_pkg::R1_W-1:0] y1a_reg, z1_reg;

    // stage 3
    logic signed [prp_pkg::R1_W-1:0] y1b_reg;
    logic signed [prp_pkg::P2_W-1:0] p_xcy_next, p_z1sy_next, p_xsy_next, p_z1cy_next;
    logic signed [prp_pkg::P2_W-1:0] p_xcy_reg, p_z1sy_reg, p_xsy_reg, p_z1cy_reg;

    // stage 4
    logic signed [prp_pkg::S2_W-1:0] s_x2_next, s_z2_next;
    logic signed [prp_pkg::R1_W-1:0] y1c_reg;
    logic signed [prp_pkg::R2_W-1:0] x2_reg, z2_reg;

    assign p_ycp_next = y_in * trig.cos_pitch;
    assign p_zsp_next = z_in * trig.sin_pitch;
    assign p_ysp_next = y_in * trig.sin_pitch;
    assign p_zcp_next = z_in * trig.cos_pitch;

    assign s_y1_next = prp_pkg::S1_W'(p_ycp_reg) - prp_pkg::S1_W'(p_zsp_reg);
    assign s_z1_next = prp_pkg::S1_W'(p_ysp_reg) + prp_pkg::S1_W'(p_zcp_reg);

    assign p_xcy_next  = xb_reg * trig.cos_yaw;
    assign p_z1sy_next = z1_reg * trig.sin_yaw;
    assign p_xsy_next  = xb_reg * trig.sin_yaw;
    assign p_z1cy_next = z1_reg * trig.cos_yaw;

    assign s_x2_next = prp_pkg::S2_W'(p_xcy_reg) - prp_pkg::S2_W'(p_z1sy_reg);
    assign s_z2_next = prp_pkg::S2_W'(p_xsy_reg) + prp_pkg::S2_W'(p_z1cy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // taking the high bits is the floor of the divide by 2^14
    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg     <= x_in;
            p_ycp_reg  <= p_ycp_next;
            p_zsp_reg  <= p_zsp_next;
            p_ysp_reg  <= p_ysp_next;
            p_zcp_reg  <= p_zcp_next;

            xb_reg     <= xa_reg;
            y1a_reg    <= s_y1_next[prp_pkg::S1_W-1:prp_pkg::TRIG_SHIFT];
            z1_reg     <= s_z1_next[prp_pkg::S1_W-1:prp_pkg::TRIG_SHIFT];

            y1b_reg    <= y1a_reg;
            p_xcy_reg  <= p_xcy_next;
            p_z1sy_reg <= p_z1sy_next;
            p_xsy_reg  <= p_xsy_next;
            p_z1cy_reg <= p_z1cy_next;

            y1c_reg    <= y1b_reg;
            x2_reg     <= s_x2_next[prp_pkg::S2_W-1:prp_pkg::TRIG_SHIFT];
            z2_reg     <= s_z2_next[prp_pkg::S2_W-1:prp_pkg::TRIG_SHIFT];
        end
    end

    assign out_valid = v_reg[3];
    assign x2        = x2_reg;
    assign z2        = z2_reg;
    assign y1        = y1c_reg;

endmodule

`default_nettype wire

// ===== rtl/prp_project.sv =====
`default_nettype none

// Perspective numerators and denominator, three stages.
module prp_project (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [prp_pkg::R2_W-1:0]      x2,
    input  logic signed [prp_pkg::R2_W-1:0]      z2,
    input  logic signed [prp_pkg::R1_W-1:0]      y1,
    input  prp_pkg::proj_cfg_t                   proj,
    output logic                                 out_valid,
    output logic                                 behind,
    output logic signed [prp_pkg::NUM_W-1:0]     nx,
    output logic signed [prp_pkg::NUM_W-1:0]     ny,
    output logic [prp_pkg::DENM_W-1:0]           den
);

    logic [2:0] v_reg;

    logic [prp_pkg::DEN_W-1:0]          fsh;
    logic signed [prp_pkg::F_W:0]       f_s;
    logic signed [prp_pkg::CTR_W:0]     cx_s, cy_s;

    // stage 5
    logic signed [prp_pkg::DEN_W-1:0]   den_next, den_reg;
    logic                               behind_next, behind_reg;
    logic signed [prp_pkg::XF_W-1:0]    x2f_next, y1f_next, x2f_reg, y1f_reg;

    // stage 6
    logic signed [prp_pkg::CXD_W-1:0]   cxd_next, cyd_next, cxd_reg, cyd_reg;
    logic signed [prp_pkg::XF_W-1:0]    x2f_b_reg, y1f_b_reg;
    logic signed [prp_pkg::DEN_W-1:0]   den_b_reg;
    logic                               behind_b_reg;

    // stage 7
    logic signed [prp_pkg::NUM_W-1:0]   nx_next, ny_next, nx_reg, ny_reg;
    logic [prp_pkg::DENM_W-1:0]         denm_next, denm_reg;
    logic                               behind_c_reg;

    assign fsh  = prp_pkg::DEN_W'(proj.focal_distance) << prp_pkg::COORD_FRAC_BITS;
    assign f_s  = $signed({1'b0, proj.focal_distance});
    assign cx_s = $signed({1'b0, proj.center_x});
    assign cy_s = $signed({1'b0, proj.center_y});

    assign den_next    = prp_pkg::DEN_W'(z2) + $signed(fsh);
    assign behind_next = den_next[prp_pkg::DEN_W-1] || (den_next == '0);
    assign x2f_next    = x2 * f_s;
    assign y1f_next    = y1 * f_s;

    assign cxd_next = den_reg * cx_s;
    assign cyd_next = den_reg * cy_s;

    assign nx_next = prp_pkg::NUM_W'(x2f_b_reg) + prp_pkg::NUM_W'(cxd_reg);
    assign ny_next = prp_pkg::NUM_W'(cyd_reg) - prp_pkg::NUM_W'(y1f_b_reg);
    // behind camera: feed the divider a harmless divisor, result is masked later
    assign denm_next = behind_b_reg ? prp_pkg::DENM_W'(1)
                                    : den_b_reg[prp_pkg::DENM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg      <= den_next;
            behind_reg   <= behind_next;
            x2f_reg      <= x2f_next;
            y1f_reg      <= y1f_next;

            cxd_reg      <= cxd_next;
            cyd_reg      <= cyd_next;
            x2f_b_reg    <= x2f_reg;
            y1f_b_reg    <= y1f_reg;
            den_b_reg    <= den_reg;
            behind_b_reg <= behind_reg;

            nx_reg       <= nx_next;
            ny_reg       <= ny_next;
            denm_reg     <= denm_next;
            behind_c_reg <= behind_b_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign behind    = behind_c_reg;
    assign nx        = nx_reg;
    assign ny        = ny_reg;
    assign den       = denm_reg;

endmodule

`default_nettype wire

// ===== rtl/prp_div_lane.sv =====
`default_nettype none

// Signed / positive divide, truncating toward zero, saturated to 16 bits.
// Magnitude and overflow check in the first stage, then one restoring step
// per stage.
module prp_div_lane (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [prp_pkg::NUM_W-1:0]     num,
    input  logic [prp_pkg::DENM_W-1:0]           den,
    output logic signed [prp_pkg::OUT_W-1:0]     result
);

    logic [prp_pkg::NUM_W-1:0]  mag_next;
    logic [prp_pkg::DIV_W-1:0]  lim;
    logic                       ovf_next;

    logic [prp_pkg::NUM_W-1:0]  rem_reg [0:prp_pkg::Q_W-1];
    logic [prp_pkg::DENM_W-1:0] den_reg [0:prp_pkg::Q_W-1];
    logic [prp_pkg::Q_W-1:0]    q_reg   [0:prp_pkg::Q_W];
    logic [prp_pkg::Q_W:0]      neg_reg;
    logic [prp_pkg::Q_W:0]      ovf_reg;

    logic [prp_pkg::Q_W-1:0]    q;

    assign mag_next = num[prp_pkg::NUM_W-1] ? prp_pkg::NUM_W'(-num)
                                            : prp_pkg::NUM_W'(num);
    assign lim      = prp_pkg::DIV_W'(den) << prp_pkg::Q_W;
    // quotient would need more than 16 bits
    assign ovf_next = prp_pkg::DIV_W'(mag_next) >= lim;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= mag_next;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[prp_pkg::NUM_W-1];
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar k = 1; k <= prp_pkg::Q_W; k++) begin : g_step
        logic [prp_pkg::NUM_W-1:0] dsh;
        logic                      take;
        logic [prp_pkg::Q_W-1:0]   q_next;

        assign dsh    = prp_pkg::NUM_W'(den_reg[k-1]) << (prp_pkg::Q_W - k);
        assign take   = rem_reg[k-1] >= dsh;
        assign q_next = q_reg[k-1] | (prp_pkg::Q_W'(take) << (prp_pkg::Q_W - k));

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]   <= q_next;
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        // last step only yields its quotient bit
        if (k < prp_pkg::Q_W) begin : g_carry
            logic [prp_pkg::NUM_W-1:0] rem_next;

            assign rem_next = take ? rem_reg[k-1] - dsh : rem_reg[k-1];

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign q = q_reg[prp_pkg::Q_W];

    always_comb begin
        if (ovf_reg[prp_pkg::Q_W]) begin
            result = neg_reg[prp_pkg::Q_W] ? prp_pkg::SAT_MIN : prp_pkg::SAT_MAX;
        end else if (neg_reg[prp_pkg::Q_W]) begin
            result = (q > prp_pkg::NEG_LIM) ? prp_pkg::SAT_MIN : $signed(~q + 1'b1);
        end else begin
            result = (q > prp_pkg::POS_LIM) ? prp_pkg::SAT_MAX : $signed(q);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prp_checker.sv =====
`default_nettype none

module prp_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_ready,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic signed [prp_pkg::OUT_W-1:0]       m_screen_x,
    input  logic signed [prp_pkg::OUT_W-1:0]       m_screen_y,
    input  logic                                   m_behind_camera
);

    // output word holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_screen_x)
                                && $stable(m_screen_y) && $stable(m_behind_camera))
        else $error("output word changed while stalled");

    a_behind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_behind_camera |-> m_screen_x == '0 && m_screen_y == '0)
        else $error("behind-camera word with nonzero screen values");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // input side blocks only with a word waiting at the output
    a_stall_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("ready dropped without an output stall");

endmodule

bind point_rotate_project_unit prp_checker u_prp_checker (.*);

`default_nettype wire
